// File: rtl/rlc_li_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLC length indicator parser package
// Shared payload types, register map and limits for the LI parser.
// ----------------------------------------------------------------------------
package rlc_li_pkg;

    // Largest number of length indicators the hardware is built for
    localparam int unsigned LiMax = 64;

    // Effective ceiling on the configured limit
    localparam int unsigned LiCapInt = (LiMax < 64) ? LiMax : 64;
    localparam logic [6:0]  LiCap    = 7'(LiCapInt);

    localparam int unsigned PaddrWidth = 3;

    // Register index codes (byte address / 4)
    localparam logic RegFixedHeaderBytes = 1'b0;
    localparam logic RegMaxLengthFields  = 1'b1;

    localparam logic [1:0] FixedHeaderBytesReset = 2'd2;
    localparam logic [6:0] MaxLengthFieldsReset  = 7'd64;

    localparam logic StatusOk      = 1'b0;
    localparam logic StatusZeroLi  = 1'b1;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       first_byte;
    } hdr_byte_t;

    typedef struct packed {
        logic [10:0] length_value;
        logic [5:0]  length_index;
        logic        status;
        logic        last;
        logic [7:0]  header_size;
        logic [6:0]  field_count;
    } li_result_t;

endpackage

// File: rtl/rlc_length_indicator_parser.sv
`timescale 1ns / 1ps
// Results are registered; one that meets a stalled output waits in the skid stage.
// Throughput: one header byte per cycle; byte_ready drops only while the skid
//   stage holds a second result behind a stalled output register.
// Reset (rst_n, async, active low): parse idle, phase 0, no results pending,
//   fixed_header_bytes = 2, max_length_fields = 64.
// ----------------------------------------------------------------------------
// RLC length indicator parser
// Unpacks E/LI pairs (two per three bytes) from the extension header of an
// RLC PDU and reports each LI; on the last, field count and (but for a zero LI) header size.
// ----------------------------------------------------------------------------
module rlc_length_indicator_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    // header byte channel
    input  logic                           byte_valid,
    output logic                           byte_ready,
    input  rlc_li_pkg::hdr_byte_t          byte_data,
    // length indicator result channel
    output logic                           li_valid,
    input  logic                           li_ready,
    output rlc_li_pkg::li_result_t         li_data,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rlc_li_pkg::PaddrWidth-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import rlc_li_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] fixed_hdr_reg;
    logic [6:0] max_fields_reg;
    logic       reg_sel;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_hdr_reg  <= FixedHeaderBytesReset;
            max_fields_reg <= MaxLengthFieldsReset;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                RegFixedHeaderBytes: fixed_hdr_reg  <= pwdata[1:0];
                RegMaxLengthFields:  max_fields_reg <= pwdata[6:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            RegFixedHeaderBytes: prdata = {30'd0, fixed_hdr_reg};
            RegMaxLengthFields:  prdata = {25'd0, max_fields_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Clamp the limit: zero acts as one, anything above the cap as the cap
    logic [6:0] limit;
    always_comb
    begin
        limit = max_fields_reg;
        if (limit == 7'd0)
        begin
            limit = 7'd1;
        end
        if (limit > LiCap)
        begin
            limit = LiCap;
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    logic [1:0] phase_reg,  phase_next;
    logic [7:0] held_reg,   held_next;
    logic [6:0] count_reg,  count_next;
    logic       active_reg, active_next;

    logic       byte_xfer;
    logic [1:0] phase_eff;
    logic [6:0] count_eff;
    logic       active_eff;
    logic       produce;
    logic       ext_bit;
    logic [10:0] li_val;
    logic [6:0] count_inc;
    logic       is_last;
    logic [9:0] size_sum;
    li_result_t new_result;

    assign byte_xfer = byte_valid && byte_ready;

    // A first byte restarts the parse with this very byte
    assign phase_eff  = byte_data.first_byte ? 2'd0 : phase_reg;
    assign count_eff  = byte_data.first_byte ? 7'd0 : count_reg;
    assign active_eff = byte_data.first_byte || active_reg;

    assign count_inc = count_eff + 7'd1;
    // fixed + ceil(12n/8) = fixed + n + ceil(n/2)
    assign size_sum  = 10'(fixed_hdr_reg) + 10'(count_inc)
                     + 10'(count_inc[6:1]) + 10'(count_inc[0]);

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        count_next  = count_reg;
        active_next = active_reg;
        produce     = 1'b0;
        ext_bit     = 1'b0;
        li_val      = 11'd0;
        is_last     = 1'b0;
        new_result  = '0;

        if (byte_xfer && active_eff)
        begin
            active_next = 1'b1;
            count_next  = count_eff;
            case (phase_eff)
                2'd0:
                begin
                    // Group start: hold the byte, no result yet
                    held_next  = byte_data.header_byte;
                    phase_next = 2'd1;
                end
                2'd1:
                begin
                    ext_bit    = held_reg[7];
                    li_val     = {held_reg[6:0], byte_data.header_byte[7:4]};
                    held_next  = byte_data.header_byte;
                    phase_next = 2'd2;
                    produce    = 1'b1;
                end
                default:
                begin
                    ext_bit    = held_reg[3];
                    li_val     = {held_reg[2:0], byte_data.header_byte};
                    phase_next = 2'd0;
                    produce    = 1'b1;
                end
            endcase

            if (produce)
            begin
                new_result.length_value = li_val;
                new_result.length_index = count_eff[5:0];
                if (li_val == 11'd0)
                begin
                    // Reserved zero LI: end the parse with a zero-LI status
                    is_last                = 1'b1;
                    new_result.status      = StatusZeroLi;
                    new_result.field_count = count_inc;
                end
                else
                begin
                    count_next        = count_inc;
                    is_last           = !ext_bit || (count_inc >= limit);
                    new_result.status = StatusOk;
                    if (is_last)
                    begin
                        new_result.header_size = size_sum[7:0];
                        new_result.field_count = count_inc + 7'd1;
                    end
                end
                new_result.last = is_last;
                if (is_last)
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 2'd0;
            held_reg   <= 8'd0;
            count_reg  <= 7'd0;
            active_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid stage
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    li_result_t out_data_reg;
    logic       skid_valid_reg;
    li_result_t skid_data_reg;
    logic       pop;

    // Accept a byte unless the skid stage is already occupied
    assign byte_ready = !skid_valid_reg;
    assign li_valid   = out_valid_reg;
    assign li_data    = out_data_reg;
    assign pop        = out_valid_reg && li_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            // Output slot frees up: advance skid first, else take the new result
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= produce;
            end
            else
            begin
                out_valid_reg <= produce;
            end
        end
        else if (produce)
        begin
            // Output stalled: hold the new result in the skid stage
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (produce)
                begin
                    skid_data_reg <= new_result;
                end
            end
            else if (produce)
            begin
                out_data_reg <= new_result;
            end
        end
        else if (produce)
        begin
            skid_data_reg <= new_result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output register is empty");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LiCap)
        else $error("parsed LI count exceeds the limit cap");

    a_zero_li_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (li_valid && li_data.status == StatusZeroLi) |-> li_data.last)
        else $error("zero LI result not marked last");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && is_last) |=> !active_reg)
        else $error("parse still active after a last result");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("byte phase out of range");

endmodule
